@@ sv/iirfb_pkg.sv @@
`timescale 1ns / 1ps

package iirfb_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W   = 32;
    localparam int COEF_W     = 32;
    localparam int GAIN_W     = 31;
    localparam int FRAC_W     = 28;
    localparam int ACC_W      = 68;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 9;
    localparam int MPL_W      = DIGIT_W * NUM_DIGITS;
    localparam int DCNT_W     = 4;
    localparam int TERM_W     = 3;

    // Filter order limits
    localparam int MAX_TAPS  = 3;
    localparam int DEF_ORDER = 3;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEFF_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEFF_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEFF_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEFF_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEFF_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEFF_2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEFF_3 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INV_GAIN   = 3'd7;

    localparam logic [GAIN_W-1:0] INV_GAIN_RESET = 31'h1000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAIN,
        S_PUSH,
        S_LOAD,
        S_MAC,
        S_ROUND,
        S_FINISH
    } t_state;

    // Round half up at the binary point, then clamp to the sample range
    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0]        sum;
        logic signed [ACC_W-FRAC_W-1:0] q;
        logic                           fits;
        sum  = acc + ACC_W'(1 << (FRAC_W - 1));
        q    = sum[ACC_W-1:FRAC_W];
        fits = (q[ACC_W-FRAC_W-1:SAMPLE_W-1] == '0)
            || (q[ACC_W-FRAC_W-1:SAMPLE_W-1] == '1);
        if (fits) begin
            return q[SAMPLE_W-1:0];
        end else if (q[ACC_W-FRAC_W-1]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

    // Clamp a one-bit-wider difference to the sample range
    function automatic logic signed [SAMPLE_W-1:0] sat_diff(
        input logic signed [SAMPLE_W:0] d
    );
        if (d[SAMPLE_W] == d[SAMPLE_W-1]) begin
            return d[SAMPLE_W-1:0];
        end else if (d[SAMPLE_W]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage

@@ sv/iir_filter_with_output_feedback_core.sv @@
`timescale 1ns / 1ps

// Direct-form-1 IIR filter with output feedback on the input.
// Input channel: i_sample_in with i_sample_valid / o_sample_ready; one sample
// per transfer. Output channel: o_correction_out with o_correction_valid /
// i_correction_ready; exactly one correction per input sample, in order.
// Config port: i_cfg_we, i_cfg_index, i_cfg_data; write only while idle.
// All products run through one shared multiply-accumulate that consumes the
// multiplier operand 4 bits per cycle (9 digits per product): first the
// corrected sample times the reciprocal gain, then one product for each
// input and output history tap.
// The block takes one sample at a time. The result sits in an output
// register; a new sample may be taken while it waits. If the receiver stalls
// when the next result is done, the block holds in its last step until the
// register frees up.
// Reset clears the histories, the coefficients to zero and the reciprocal
// gain to 1.0.
module iir_filter_with_output_feedback_core #(
    parameter int ORDER = iirfb_pkg::DEF_ORDER
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_sample_valid,
    output logic                                  o_sample_ready,
    input  logic signed [iirfb_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                  o_correction_valid,
    input  logic                                  i_correction_ready,
    output logic signed [iirfb_pkg::SAMPLE_W-1:0] o_correction_out,
    input  logic                                  i_cfg_we,
    input  logic [iirfb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [iirfb_pkg::COEF_W-1:0]          i_cfg_data
);

    localparam int TAPS   = (ORDER < 1) ? 1 :
                            ((ORDER > iirfb_pkg::MAX_TAPS) ? iirfb_pkg::MAX_TAPS : ORDER);
    localparam int NTERMS = 2 * TAPS + 1;
    localparam int SW     = iirfb_pkg::SAMPLE_W;
    localparam int AW     = iirfb_pkg::ACC_W;
    localparam int MW     = iirfb_pkg::MPL_W;
    localparam int DW     = iirfb_pkg::DIGIT_W;

    iirfb_pkg::t_state r_state, n_state;

    // Coefficients and histories
    logic signed [iirfb_pkg::COEF_W-1:0] r_ff [iirfb_pkg::MAX_TAPS+1];
    logic signed [iirfb_pkg::COEF_W-1:0] r_fb [iirfb_pkg::MAX_TAPS];
    logic [iirfb_pkg::GAIN_W-1:0]        r_inv_gain;
    logic signed [SW-1:0]                r_xh [TAPS+1];
    logic signed [SW-1:0]                r_yh [TAPS];

    // Serial MAC datapath
    logic signed [MW-1:0]               r_mplier;
    logic signed [AW-1:0]               r_mcand;
    logic signed [AW-1:0]               r_acc;
    logic [iirfb_pkg::DCNT_W-1:0]       r_digit;
    logic [iirfb_pkg::TERM_W-1:0]       r_term;
    logic signed [SW-1:0]               r_y;
    logic signed [SW-1:0]               r_out;
    logic                               r_out_valid;

    // Control decodes
    logic c_accept, c_step, c_push, c_load, c_round, c_emit, c_next_term;
    logic w_last_digit, w_last_term, w_out_free;
    logic signed [DW:0]                 w_digit;
    logic signed [AW-1:0]               w_pp;
    logic signed [SW:0]                 w_corrected;
    logic signed [SW-1:0]               w_opnd;
    logic signed [iirfb_pkg::COEF_W-1:0] w_coef;

    assign w_last_digit = (r_digit == iirfb_pkg::DCNT_W'(iirfb_pkg::NUM_DIGITS - 1));
    assign w_last_term  = (r_term == iirfb_pkg::TERM_W'(NTERMS - 1));
    assign w_out_free   = !r_out_valid || i_correction_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            iirfb_pkg::S_IDLE:   if (i_sample_valid) n_state = iirfb_pkg::S_GAIN;
            iirfb_pkg::S_GAIN:   if (w_last_digit) n_state = iirfb_pkg::S_PUSH;
            iirfb_pkg::S_PUSH:   n_state = iirfb_pkg::S_LOAD;
            iirfb_pkg::S_LOAD:   n_state = iirfb_pkg::S_MAC;
            iirfb_pkg::S_MAC: begin
                if (w_last_digit) begin
                    n_state = w_last_term ? iirfb_pkg::S_ROUND : iirfb_pkg::S_LOAD;
                end
            end
            iirfb_pkg::S_ROUND:  n_state = iirfb_pkg::S_FINISH;
            iirfb_pkg::S_FINISH: if (w_out_free) n_state = iirfb_pkg::S_IDLE;
            default:             n_state = iirfb_pkg::S_IDLE;
        endcase
    end

    // State decodes
    always_comb begin
        o_sample_ready = 1'b0;
        c_step         = 1'b0;
        c_push         = 1'b0;
        c_load         = 1'b0;
        c_round        = 1'b0;
        c_emit         = 1'b0;
        c_next_term    = 1'b0;
        case (r_state)
            iirfb_pkg::S_IDLE:   o_sample_ready = 1'b1;
            iirfb_pkg::S_GAIN:   c_step = 1'b1;
            iirfb_pkg::S_PUSH:   c_push = 1'b1;
            iirfb_pkg::S_LOAD:   c_load = 1'b1;
            iirfb_pkg::S_MAC: begin
                c_step      = 1'b1;
                c_next_term = w_last_digit;
            end
            iirfb_pkg::S_ROUND:  c_round = 1'b1;
            iirfb_pkg::S_FINISH: c_emit = w_out_free;
            default:             o_sample_ready = 1'b0;
        endcase
    end

    assign c_accept = o_sample_ready && i_sample_valid;

    // Sample plus previous output, exact
    assign w_corrected = (SW+1)'(i_sample_in) + (SW+1)'(r_yh[0]);

    // Lowest digits are unsigned, the top digit carries the sign
    always_comb begin
        if (w_last_digit) begin
            w_digit = {r_mplier[DW-1], r_mplier[DW-1:0]};
        end else begin
            w_digit = {1'b0, r_mplier[DW-1:0]};
        end
    end

    assign w_pp = $signed(w_digit) * r_mcand;

    // Operand and coefficient for the current term
    always_comb begin
        w_opnd = '0;
        w_coef = '0;
        for (int k = 0; k <= TAPS; k++) begin
            if (r_term == iirfb_pkg::TERM_W'(k)) begin
                w_opnd = r_xh[k];
                w_coef = r_ff[k];
            end
        end
        for (int k = 0; k < TAPS; k++) begin
            if (r_term == iirfb_pkg::TERM_W'(TAPS + 1 + k)) begin
                w_opnd = r_yh[k];
                w_coef = r_fb[k];
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iirfb_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_digit     <= '0;
            r_term      <= '0;
        end else begin
            r_state <= n_state;
            if (c_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_correction_ready) begin
                r_out_valid <= 1'b0;
            end
            if (c_accept || c_load) begin
                r_digit <= '0;
            end else if (c_step) begin
                r_digit <= r_digit + 1'b1;
            end
            if (c_push) begin
                r_term <= '0;
            end else if (c_next_term) begin
                r_term <= r_term + 1'b1;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= iirfb_pkg::MAX_TAPS; k++) r_ff[k] <= '0;
            for (int k = 0; k < iirfb_pkg::MAX_TAPS; k++) r_fb[k] <= '0;
            r_inv_gain <= iirfb_pkg::INV_GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                iirfb_pkg::REG_FF_COEFF_0: r_ff[0] <= i_cfg_data;
                iirfb_pkg::REG_FF_COEFF_1: r_ff[1] <= i_cfg_data;
                iirfb_pkg::REG_FF_COEFF_2: r_ff[2] <= i_cfg_data;
                iirfb_pkg::REG_FF_COEFF_3: r_ff[3] <= i_cfg_data;
                iirfb_pkg::REG_FB_COEFF_1: r_fb[0] <= i_cfg_data;
                iirfb_pkg::REG_FB_COEFF_2: r_fb[1] <= i_cfg_data;
                iirfb_pkg::REG_FB_COEFF_3: r_fb[2] <= i_cfg_data;
                iirfb_pkg::REG_INV_GAIN:   r_inv_gain <= i_cfg_data[iirfb_pkg::GAIN_W-1:0];
                default:                   r_inv_gain <= r_inv_gain;
            endcase
        end
    end

    // Input and output histories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= TAPS; k++) r_xh[k] <= '0;
            for (int k = 0; k < TAPS; k++) r_yh[k] <= '0;
        end else begin
            if (c_push) begin
                for (int k = TAPS; k > 0; k--) r_xh[k] <= r_xh[k-1];
                r_xh[0] <= iirfb_pkg::round_sat(r_acc);
            end
            if (c_emit) begin
                for (int k = TAPS - 1; k > 0; k--) r_yh[k] <= r_yh[k-1];
                r_yh[0] <= r_y;
            end
        end
    end

    // Digit-serial multiply-accumulate
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_mplier <= MW'(w_corrected);
            r_mcand  <= AW'({1'b0, r_inv_gain});
            r_acc    <= '0;
        end else if (c_load) begin
            r_mplier <= MW'(w_opnd);
            r_mcand  <= AW'(w_coef);
        end else if (c_step) begin
            r_mplier <= r_mplier >>> DW;
            r_mcand  <= r_mcand <<< DW;
            r_acc    <= r_acc + w_pp;
        end else if (c_push) begin
            r_acc <= '0;
        end
        if (c_round) begin
            r_y <= iirfb_pkg::round_sat(r_acc);
        end
        if (c_emit) begin
            r_out <= iirfb_pkg::sat_diff((SW+1)'(r_y) - (SW+1)'(r_yh[0]));
        end
    end

    assign o_correction_valid = r_out_valid;
    assign o_correction_out   = r_out;

endmodule
